>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while in reset.
`define AUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on the following clock edge.
`define AUT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aut_pkg.sv
`timescale 1ns / 1ps

package aut_pkg;

  localparam int unsigned SITES   = 256;
  localparam int unsigned SITE_W  = $clog2(SITES);
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTE_W  = 48;
  localparam int unsigned MODE_W  = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC_CACHE = 3'd0,
    MODE_ALLOC       = 3'd1,
    MODE_ADD_BYTES   = 3'd2,
    MODE_DEL_BYTES   = 3'd3,
    MODE_READ        = 3'd4
  } mode_e;

  typedef struct packed {
    logic [CNT_W-1:0]  alloc;
    logic [CNT_W-1:0]  hit;
    logic [CNT_W-1:0]  miss;
    logic [CNT_W-1:0]  not_fit;
    logic [BYTE_W-1:0] used;
    logic [BYTE_W-1:0] peak;
    logic [BYTE_W-1:0] fb_used;
    logic [BYTE_W-1:0] fb_peak;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  live_peak;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

>>> rtl/allocation_site_usage_tracker.sv
`timescale 1ns / 1ps
// Per-site allocation statistics tracker. An item is taken when start is high
// and busy is low; each item has a read step, which fetches the site's record
// from the record memory, and an update step, which writes it back. The result appears
// on the output ports for exactly one cycle with done_o high, in the cycle after
// the update, and a new item may be started in that same cycle; the block takes
// no new item until the last one is written back. The receiver cannot stall: a result not
// taken while done_o is high is lost. All site records read as zero after
// reset. sites_in_use is written through the cfg channel, which is always ready,
// and may be changed only while the block is idle.
`include "assert_macros.svh"

module allocation_site_usage_tracker import aut_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [SITE_W-1:0] site_i,
  input  logic              fits_i,
  input  logic              in_cache_i,
  input  logic [BYTE_W-1:0] byte_count_i,
  input  logic              on_fallback_i,
  output logic              done_o,
  output logic              error_o,
  output logic [CNT_W-1:0]  alloc_total_o,
  output logic [CNT_W-1:0]  hit_total_o,
  output logic [CNT_W-1:0]  miss_total_o,
  output logic [CNT_W-1:0]  not_fit_total_o,
  output logic [BYTE_W-1:0] used_bytes_o,
  output logic [BYTE_W-1:0] peak_bytes_o,
  output logic [BYTE_W-1:0] fallback_used_bytes_o,
  output logic [BYTE_W-1:0] fallback_peak_bytes_o,
  output logic [CNT_W-1:0]  live_objects_o,
  output logic [CNT_W-1:0]  peak_live_objects_o
);

  cmd_t cmd;
  rec_t res;

  assign cfg_ready_o = 1'b1;

  aut_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  aut_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .site_i        (site_i),
    .fits_i        (fits_i),
    .in_cache_i    (in_cache_i),
    .byte_count_i  (byte_count_i),
    .on_fallback_i (on_fallback_i),
    .error_o       (error_o),
    .res_o         (res)
  );

  assign alloc_total_o         = res.alloc;
  assign hit_total_o           = res.hit;
  assign miss_total_o          = res.miss;
  assign not_fit_total_o       = res.not_fit;
  assign used_bytes_o          = res.used;
  assign peak_bytes_o          = res.peak;
  assign fallback_used_bytes_o = res.fb_used;
  assign fallback_peak_bytes_o = res.fb_peak;
  assign live_objects_o        = res.live;
  assign peak_live_objects_o   = res.live_peak;

  `AUT_ASSERT(a_done_idle, done_o |-> !busy, "result strobe while busy")
  `AUT_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without prior work")
  `AUT_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done_o, "start not taken")
  `AUT_ASSERT(a_err_zero, (done_o && error_o) |-> (alloc_total_o == '0 && used_bytes_o == '0
    && live_objects_o == '0), "rejected site returned data")

endmodule

>>> rtl/aut_ctrl.sv
`timescale 1ns / 1ps

module aut_ctrl import aut_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign done_d      = (state_q == S_EXEC);
  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign cmd_o.capture = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec    = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

endmodule

>>> rtl/aut_dp.sv
`timescale 1ns / 1ps

module aut_dp import aut_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [SITE_W-1:0] site_i,
  input  logic              fits_i,
  input  logic              in_cache_i,
  input  logic [BYTE_W-1:0] byte_count_i,
  input  logic              on_fallback_i,
  output logic              error_o,
  output rec_t              res_o
);

  logic [CFG_W-1:0]  sites_q;
  rec_t              mem_q [SITES];
  logic [SITES-1:0]  vld_q;
  rec_t              rd_raw_q;
  logic              rd_vld_q;
  logic [MODE_W-1:0] mode_q;
  logic [SITE_W-1:0] site_q;
  logic              fits_q;
  logic              hit_q;
  logic [BYTE_W-1:0] bytes_q;
  logic              fb_q;
  logic              err_q;
  rec_t              res_q;
  logic              res_err_q;

  rec_t              cur;
  rec_t              nxt;
  logic [BYTE_W-1:0] sel_used;
  logic [BYTE_W-1:0] sel_peak;
  logic [BYTE_W-1:0] new_used;
  logic [BYTE_W-1:0] new_peak;
  logic [BYTE_W:0]   byte_sum;
  logic [CNT_W-1:0]  live_inc;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    sat_inc = (&x) ? x : x + CNT_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sites_q   <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      err_q     <= 1'b0;
      res_err_q <= 1'b0;
    end else begin
      if (cfg_we_i) sites_q <= cfg_data_i;
      if (cmd_i.capture) begin
        rd_vld_q <= vld_q[site_i];
        err_q    <= {1'b0, site_i} >= sites_q;
      end
      if (cmd_i.exec) begin
        res_err_q <= err_q;
        if (!err_q) vld_q[site_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_raw_q <= mem_q[site_i];
      mode_q   <= mode_i;
      site_q   <= site_i;
      fits_q   <= fits_i;
      hit_q    <= in_cache_i;
      bytes_q  <= byte_count_i;
      fb_q     <= on_fallback_i;
    end
    if (cmd_i.exec) begin
      if (!err_q) mem_q[site_q] <= nxt;
      res_q <= err_q ? '0 : nxt;
    end
  end

  assign cur      = rd_vld_q ? rd_raw_q : '0;
  assign sel_used = fb_q ? cur.fb_used : cur.used;
  assign sel_peak = fb_q ? cur.fb_peak : cur.peak;
  assign byte_sum = {1'b0, sel_used} + {1'b0, bytes_q};
  assign live_inc = sat_inc(cur.live);

  always_comb begin
    nxt      = cur;
    new_used = sel_used;
    new_peak = sel_peak;
    unique case (mode_q)
      MODE_ALLOC_CACHE, MODE_ALLOC: begin
        nxt.alloc = sat_inc(cur.alloc);
        if (mode_q == MODE_ALLOC_CACHE) begin
          if (hit_q) nxt.hit  = sat_inc(cur.hit);
          else       nxt.miss = sat_inc(cur.miss);
        end
        if (!fits_q) nxt.not_fit = sat_inc(cur.not_fit);
      end
      MODE_ADD_BYTES: begin
        new_used = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
        if (sel_peak < new_used) new_peak = new_used;
        nxt.live = live_inc;
        if (cur.live_peak < live_inc) nxt.live_peak = live_inc;
      end
      MODE_DEL_BYTES: begin
        if (sel_used >= bytes_q) new_used = sel_used - bytes_q;
        if (cur.live != '0) nxt.live = cur.live - CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (fb_q) begin
      nxt.fb_used = new_used;
      nxt.fb_peak = new_peak;
    end else begin
      nxt.used = new_used;
      nxt.peak = new_peak;
    end
  end

  assign error_o = res_err_q;
  assign res_o   = res_q;

endmodule

>>> dv/allocation_site_usage_tracker_tb.sv
`timescale 1ns / 1ps

module allocation_site_usage_tracker_tb;
  import aut_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [BYTE_W-1:0] BYTE_MAX = '1;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RAND_PER_PHASE = 225;
  localparam int unsigned PHASES         = 6;

  typedef struct packed {
    logic err;
    rec_t rec;
  } outcome_t;

  typedef struct {
    bit                is_cfg;
    logic [CFG_W-1:0]  cfg;
    logic [MODE_W-1:0] mode;
    logic [SITE_W-1:0] site;
    logic              fits;
    logic              hit;
    logic [BYTE_W-1:0] nbytes;
    logic              fb;
    bit                typed;
    outcome_t          want;
  } step_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] mode_i;
  logic [SITE_W-1:0] site_i;
  logic              fits_i;
  logic              in_cache_i;
  logic [BYTE_W-1:0] byte_count_i;
  logic              on_fallback_i;
  logic              done_o;
  logic              error_o;
  logic [CNT_W-1:0]  alloc_total_o;
  logic [CNT_W-1:0]  hit_total_o;
  logic [CNT_W-1:0]  miss_total_o;
  logic [CNT_W-1:0]  not_fit_total_o;
  logic [BYTE_W-1:0] used_bytes_o;
  logic [BYTE_W-1:0] peak_bytes_o;
  logic [BYTE_W-1:0] fallback_used_bytes_o;
  logic [BYTE_W-1:0] fallback_peak_bytes_o;
  logic [CNT_W-1:0]  live_objects_o;
  logic [CNT_W-1:0]  peak_live_objects_o;

  // typed expectation travels with the transaction it belongs to
  logic     typed_i;
  outcome_t typed_want;

  rec_t             site_stats [SITES];
  logic [CFG_W-1:0] sites_cfg;
  outcome_t         stats_due [$];
  step_row_t        directed_rows [$];

  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_rejected;
  int unsigned n_cfg;
  int unsigned burst_left;

  allocation_site_usage_tracker DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_data_i           (cfg_data_i),
    .start                (start),
    .busy                 (busy),
    .mode_i               (mode_i),
    .site_i               (site_i),
    .fits_i               (fits_i),
    .in_cache_i           (in_cache_i),
    .byte_count_i         (byte_count_i),
    .on_fallback_i        (on_fallback_i),
    .done_o               (done_o),
    .error_o              (error_o),
    .alloc_total_o        (alloc_total_o),
    .hit_total_o          (hit_total_o),
    .miss_total_o         (miss_total_o),
    .not_fit_total_o      (not_fit_total_o),
    .used_bytes_o         (used_bytes_o),
    .peak_bytes_o         (peak_bytes_o),
    .fallback_used_bytes_o(fallback_used_bytes_o),
    .fallback_peak_bytes_o(fallback_peak_bytes_o),
    .live_objects_o       (live_objects_o),
    .peak_live_objects_o  (peak_live_objects_o)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] x);
    return (&x) ? x : x + 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] bytes_add(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_W] ? BYTE_MAX : s[BYTE_W-1:0];
  endfunction

  function automatic outcome_t update_site_stats(logic [MODE_W-1:0] mode, logic [SITE_W-1:0] site,
                                                  logic fits, logic hit,
                                                  logic [BYTE_W-1:0] nbytes, logic fb);
    outcome_t          res;
    rec_t              r;
    logic [BYTE_W-1:0] side_used;
    logic [BYTE_W-1:0] side_peak;
    res = '0;
    if ({1'b0, site} >= sites_cfg) begin
      res.err = 1'b1;
      return res;
    end
    r = site_stats[site];
    side_used = fb ? r.fb_used : r.used;
    side_peak = fb ? r.fb_peak : r.peak;
    case (mode)
      MODE_ALLOC_CACHE, MODE_ALLOC: begin
        r.alloc = count_up(r.alloc);
        if (mode == MODE_ALLOC_CACHE) begin
          if (hit) r.hit = count_up(r.hit);
          else r.miss = count_up(r.miss);
        end
        if (!fits) r.not_fit = count_up(r.not_fit);
      end
      MODE_ADD_BYTES: begin
        side_used = bytes_add(side_used, nbytes);
        if (side_peak < side_used) side_peak = side_used;
        r.live = count_up(r.live);
        if (r.live_peak < r.live) r.live_peak = r.live;
      end
      MODE_DEL_BYTES: begin
        if (side_used >= nbytes) side_used = side_used - nbytes;
        if (r.live != '0) r.live = r.live - 1'b1;
      end
      default: ;
    endcase
    if (fb) begin
      r.fb_used = side_used;
      r.fb_peak = side_peak;
    end else begin
      r.used = side_used;
      r.peak = side_peak;
    end
    site_stats[site] = r;
    res.rec = r;
    return res;
  endfunction

  function automatic outcome_t rec_of(logic err, logic [CNT_W-1:0] alloc, logic [CNT_W-1:0] hit,
                                      logic [CNT_W-1:0] miss, logic [CNT_W-1:0] nf,
                                      logic [BYTE_W-1:0] used, logic [BYTE_W-1:0] peak,
                                      logic [BYTE_W-1:0] fbu, logic [BYTE_W-1:0] fbp,
                                      logic [CNT_W-1:0] live, logic [CNT_W-1:0] lpeak);
    outcome_t o;
    o.err           = err;
    o.rec.alloc     = alloc;
    o.rec.hit       = hit;
    o.rec.miss      = miss;
    o.rec.not_fit   = nf;
    o.rec.used      = used;
    o.rec.peak      = peak;
    o.rec.fb_used   = fbu;
    o.rec.fb_peak   = fbp;
    o.rec.live      = live;
    o.rec.live_peak = lpeak;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0d] %s: got 0x%0h, want 0x%0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic compare_result(outcome_t w);
    check_field("error", 64'(error_o), 64'(w.err));
    check_field("alloc_total", 64'(alloc_total_o), 64'(w.rec.alloc));
    check_field("hit_total", 64'(hit_total_o), 64'(w.rec.hit));
    check_field("miss_total", 64'(miss_total_o), 64'(w.rec.miss));
    check_field("not_fit_total", 64'(not_fit_total_o), 64'(w.rec.not_fit));
    check_field("used_bytes", 64'(used_bytes_o), 64'(w.rec.used));
    check_field("peak_bytes", 64'(peak_bytes_o), 64'(w.rec.peak));
    check_field("fallback_used_bytes", 64'(fallback_used_bytes_o), 64'(w.rec.fb_used));
    check_field("fallback_peak_bytes", 64'(fallback_peak_bytes_o), 64'(w.rec.fb_peak));
    check_field("live_objects", 64'(live_objects_o), 64'(w.rec.live));
    check_field("peak_live_objects", 64'(peak_live_objects_o), 64'(w.rec.live_peak));
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               stats_due.size());
      $display("allocation_site_usage_tracker: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin : monitor
    outcome_t o;
    if (rst_ni) begin
      if (done_o) begin
        n_results++;
        if (error_o === 1'b1) n_rejected++;
        if (stats_due.size() == 0) report_mismatch("result with none outstanding", 0, 0);
        else compare_result(stats_due.pop_front());
      end
      if (start && !busy) begin
        o = update_site_stats(mode_i, site_i, fits_i, in_cache_i, byte_count_i, on_fallback_i);
        stats_due.push_back(typed_i ? typed_want : o);
        n_items++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sites_cfg = cfg_data_i;
        n_cfg++;
      end
    end
  end

  task automatic issue(logic [MODE_W-1:0] mode, logic [SITE_W-1:0] site, logic fits,
                       logic hit, logic [BYTE_W-1:0] nbytes, logic fb,
                       bit typed, outcome_t want);
    mode_i        <= mode;
    site_i        <= site;
    fits_i        <= fits;
    in_cache_i    <= hit;
    byte_count_i  <= nbytes;
    on_fallback_i <= fb;
    typed_i       <= typed;
    typed_want    <= want;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // bursts of back-to-back transactions separated by random gaps
  task automatic pace_sender();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_sites(logic [CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_cfg(logic [CFG_W-1:0] v);
    step_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg = v;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_row(bit typed, logic [MODE_W-1:0] mode, logic [SITE_W-1:0] site,
                                  logic fits, logic hit, logic [BYTE_W-1:0] nbytes, logic fb,
                                  outcome_t want);
    step_row_t row;
    row = '{default: '0};
    row.typed = typed;
    row.mode = mode;
    row.site = site;
    row.fits = fits;
    row.hit = hit;
    row.nbytes = nbytes;
    row.fb = fb;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic random_item();
    logic [MODE_W-1:0] mode;
    logic [SITE_W-1:0] site;
    logic [BYTE_W-1:0] nbytes;
    logic              fb;
    int unsigned       r;
    int unsigned       hot_top;
    r = $urandom_range(0, 99);
    if (r < 20) mode = MODE_ALLOC_CACHE;
    else if (r < 35) mode = MODE_ALLOC;
    else if (r < 60) mode = MODE_ADD_BYTES;
    else if (r < 85) mode = MODE_DEL_BYTES;
    else if (r < 93) mode = MODE_READ;
    else mode = MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
    r = $urandom_range(0, 99);
    if (sites_cfg == 0 || r >= 85) begin
      site = SITE_W'($urandom_range(0, SITES - 1));
    end else if (r < 55) begin
      hot_top = (sites_cfg > 8) ? 7 : sites_cfg - 1;
      site = SITE_W'($urandom_range(0, hot_top));
    end else begin
      site = SITE_W'($urandom_range(0, sites_cfg - 1));
    end
    fb = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 40) nbytes = BYTE_W'($urandom_range(0, 4095));
    else if (r < 60) nbytes = BYTE_W'({$urandom, $urandom});
    else if (r < 80) nbytes = fb ? site_stats[site].fb_used : site_stats[site].used;
    else nbytes = {16'hFFFF, $urandom};
    issue(mode, site, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), nbytes, fb,
          1'b0, '0);
    pace_sender();
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] phase_cfg [PHASES];
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    start         <= 1'b0;
    mode_i        <= '0;
    site_i        <= '0;
    fits_i        <= 1'b0;
    in_cache_i    <= 1'b0;
    byte_count_i  <= '0;
    on_fallback_i <= 1'b0;
    typed_i       <= 1'b0;
    typed_want    <= '0;
    sites_cfg = '0;
    foreach (site_stats[i]) site_stats[i] = '0;
    cycle_count = 0;
    mismatches = 0;
    n_items = 0;
    n_results = 0;
    n_rejected = 0;
    n_cfg = 0;
    burst_left = 0;

    // no sites defined after reset: everything is rejected
    add_row(1, MODE_READ, 0, 1, 0, 0, 0, rec_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(1, MODE_SPARE_7, 255, 1, 1, BYTE_MAX, 1, rec_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cfg(CFG_W'(SITES));
    add_row(1, MODE_ALLOC_CACHE, 0, 0, 1, 0, 0, rec_of(0, 1, 1, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(1, MODE_ALLOC_CACHE, 255, 1, 0, 0, 0, rec_of(0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(1, MODE_ALLOC, 1, 0, 1, 0, 0, rec_of(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    // byte saturation, then removal with too few bytes and live count at zero
    add_row(1, MODE_ADD_BYTES, 2, 1, 0, BYTE_MAX, 0,
            rec_of(0, 0, 0, 0, 0, BYTE_MAX, BYTE_MAX, 0, 0, 1, 1));
    add_row(1, MODE_ADD_BYTES, 2, 1, 0, BYTE_MAX, 0,
            rec_of(0, 0, 0, 0, 0, BYTE_MAX, BYTE_MAX, 0, 0, 2, 2));
    add_row(1, MODE_DEL_BYTES, 2, 1, 0, 1, 0,
            rec_of(0, 0, 0, 0, 0, BYTE_MAX - 1, BYTE_MAX, 0, 0, 1, 2));
    add_row(0, MODE_DEL_BYTES, 2, 1, 0, BYTE_MAX, 0, '0);
    add_row(0, MODE_DEL_BYTES, 2, 0, 1, 0, 0, '0);
    add_row(1, MODE_ADD_BYTES, 3, 1, 0, 100, 1, rec_of(0, 0, 0, 0, 0, 0, 0, 100, 100, 1, 1));
    add_row(0, MODE_DEL_BYTES, 3, 1, 0, 40, 1, '0);
    add_row(0, MODE_DEL_BYTES, 3, 1, 0, 61, 1, '0);
    add_row(0, MODE_DEL_BYTES, 3, 1, 0, 60, 1, '0);
    add_row(0, MODE_READ, 3, 0, 0, BYTE_MAX, 1, '0);
    add_row(0, MODE_SPARE_5, 0, 0, 0, 5, 0, '0);
    add_row(0, MODE_SPARE_6, 1, 0, 1, 5, 1, '0);
    add_row(0, MODE_SPARE_7, 2, 1, 1, BYTE_MAX, 0, '0);
    add_row(0, MODE_ADD_BYTES, 4, 0, 0, 0, 0, '0);
    add_cfg(1);
    add_row(1, MODE_READ, 1, 1, 1, 0, 0, rec_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(0, MODE_ALLOC, 0, 1, 0, 0, 1, '0);
    add_row(1, MODE_ADD_BYTES, 255, 1, 1, 7, 1, rec_of(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_sites(directed_rows[i].cfg);
      end else begin
        issue(directed_rows[i].mode, directed_rows[i].site, directed_rows[i].fits,
              directed_rows[i].hit, directed_rows[i].nbytes, directed_rows[i].fb,
              directed_rows[i].typed, directed_rows[i].want);
        pace_sender();
      end
    end

    phase_cfg[0] = CFG_W'(SITES);
    phase_cfg[1] = 1;
    phase_cfg[2] = 0;
    phase_cfg[3] = CFG_W'($urandom_range(2, SITES - 1));
    phase_cfg[4] = CFG_W'(SITES - 1);
    phase_cfg[5] = CFG_W'(SITES);
    for (int p = 0; p < PHASES; p++) begin
      write_sites(phase_cfg[p]);
      repeat (RAND_PER_PHASE) random_item();
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions (%0d rejected by site range) over %0d config writes",
             n_items, n_rejected, n_cfg);
    $display("%0d results checked, %0d field mismatches", n_results, mismatches);
    if (mismatches == 0) begin
      $display("allocation_site_usage_tracker: match");
    end else begin
      $display("allocation_site_usage_tracker: mismatch");
    end
    $finish;
  end

endmodule
